@@ src/mdio45_pkg.sv @@
// ----------------------------------------------------------------------------
// mdio45_pkg
// Shared types, register offsets and frame constants for the Clause 45
// management master register block.
// ----------------------------------------------------------------------------
package mdio45_pkg;

    localparam int MDC_HALF_PERIOD = 4;
    localparam int PREAMBLE_BITS   = 32;

    localparam logic [7:0] OFS_CMD    = 8'h61;
    localparam logic [7:0] OFS_DEV    = 8'h62;
    localparam logic [7:0] OFS_PORT   = 8'h63;
    localparam logic [7:0] OFS_REG_HI = 8'h64;
    localparam logic [7:0] OFS_REG_LO = 8'h65;
    localparam logic [7:0] OFS_WD_HI  = 8'h66;
    localparam logic [7:0] OFS_WD_LO  = 8'h67;
    localparam logic [7:0] OFS_RD_HI  = 8'h68;
    localparam logic [7:0] OFS_RD_LO  = 8'h69;

    localparam logic [7:0]  DIV_LIMIT    = 8'(MDC_HALF_PERIOD);
    localparam logic [6:0]  BIT_TA_SAMPLE = 7'(PREAMBLE_BITS + 15);
    localparam logic [6:0]  BIT_DATA_FIRST = 7'(PREAMBLE_BITS + 16);
    localparam logic [6:0]  BIT_RELEASE  = 7'(PREAMBLE_BITS + 14);
    localparam logic [6:0]  FRAME_LEN    = 7'(PREAMBLE_BITS + 32);
    localparam logic [63:0] PRE_MASK     = ~({64{1'b1}} >> PREAMBLE_BITS);

    localparam logic [1:0] OP_ADDRESS = 2'd0;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    typedef enum logic [3:0] {
        REG_NONE,
        REG_CMD,
        REG_DEV,
        REG_PORT,
        REG_REG_HI,
        REG_REG_LO,
        REG_WD_HI,
        REG_WD_LO,
        REG_RD_HI,
        REG_RD_LO
    } reg_sel_t;

    typedef struct packed {
        cmd_kind_t  kind;
        reg_sel_t   sel;
        logic [7:0] data;
        logic       line;
    } cmd_t;

    function automatic logic [63:0] build_frame(
        input logic [1:0]  opcode,
        input logic [4:0]  port,
        input logic [4:0]  dev,
        input logic [1:0]  ta,
        input logic [15:0] data
    );
        logic [31:0] w;
        w = {2'b00, opcode, port, dev, ta, data};
        return PRE_MASK | ({32'd0, w} << (32 - PREAMBLE_BITS));
    endfunction

endpackage

@@ src/mdio45_front.sv @@
// ----------------------------------------------------------------------------
// mdio45_front
// Classifies an incoming beat into an operation kind and a decoded register
// select, ready for the command queue.
// ----------------------------------------------------------------------------
module mdio45_front (
    input  logic [1:0]      mode,
    input  logic [7:0]      reg_offset,
    input  logic [7:0]      write_byte,
    input  logic            mdio_in,
    output mdio45_pkg::cmd_t cmd
);

    mdio45_pkg::cmd_kind_t kind;
    mdio45_pkg::reg_sel_t  sel;

    always_comb begin
        case (mode)
            mdio45_pkg::CMD_READ:  kind = mdio45_pkg::CMD_READ;
            mdio45_pkg::CMD_WRITE: kind = mdio45_pkg::CMD_WRITE;
            mdio45_pkg::CMD_TICK:  kind = mdio45_pkg::CMD_TICK;
            default:               kind = mdio45_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        case (reg_offset)
            mdio45_pkg::OFS_CMD:    sel = mdio45_pkg::REG_CMD;
            mdio45_pkg::OFS_DEV:    sel = mdio45_pkg::REG_DEV;
            mdio45_pkg::OFS_PORT:   sel = mdio45_pkg::REG_PORT;
            mdio45_pkg::OFS_REG_HI: sel = mdio45_pkg::REG_REG_HI;
            mdio45_pkg::OFS_REG_LO: sel = mdio45_pkg::REG_REG_LO;
            mdio45_pkg::OFS_WD_HI:  sel = mdio45_pkg::REG_WD_HI;
            mdio45_pkg::OFS_WD_LO:  sel = mdio45_pkg::REG_WD_LO;
            mdio45_pkg::OFS_RD_HI:  sel = mdio45_pkg::REG_RD_HI;
            mdio45_pkg::OFS_RD_LO:  sel = mdio45_pkg::REG_RD_LO;
            default:                sel = mdio45_pkg::REG_NONE;
        endcase
    end

    assign cmd = '{kind: kind, sel: sel, data: write_byte, line: mdio_in};

endmodule

@@ src/mdio45_queue.sv @@
// ----------------------------------------------------------------------------
// mdio45_queue
// Two-entry command queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module mdio45_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  mdio45_pkg::cmd_t push_cmd,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mdio45_pkg::cmd_t pop_cmd
);

    mdio45_pkg::cmd_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/mdio45_back.sv @@
// ----------------------------------------------------------------------------
// mdio45_back
// Register file, frame shifter and MDC divider. Holds the result beat in an
// output register; executes one queued command per cycle unless back-pressured.
// ----------------------------------------------------------------------------
module mdio45_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  mdio45_pkg::cmd_t cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_read_byte,
    output logic             m_mdc,
    output logic             m_mdio_out,
    output logic             m_mdio_drive,
    output logic [1:0]       m_port_select,
    output logic             m_busy_res
);

    logic [4:0]  port_addr_reg,  port_addr_next;
    logic [4:0]  dev_addr_reg,   dev_addr_next;
    logic [1:0]  opcode_reg,     opcode_next;
    logic [1:0]  if_sel_reg,     if_sel_next;
    logic [15:0] reg_addr_reg,   reg_addr_next;
    logic [15:0] wdata_reg,      wdata_next;
    logic [15:0] rdata_reg,      rdata_next;
    logic        busy_reg,       busy_next;
    logic        rvalid_reg,     rvalid_next;
    logic [63:0] shift_reg,      shift_next;
    logic [6:0]  bit_cnt_reg,    bit_cnt_next;
    logic [7:0]  div_cnt_reg,    div_cnt_next;
    logic        clk_lvl_reg,    clk_lvl_next;
    logic        ta_reg,         ta_next;

    logic        out_valid_reg;
    logic [7:0]  read_byte_reg,  read_byte_next;
    logic        mdio_out_reg,   mdio_out_next;
    logic        drive_reg,      drive_next;

    logic        pop;
    logic [7:0]  div_inc;
    logic [6:0]  bit_inc;
    logic        start_rd;
    logic [15:0] start_data;

    assign cmd_ready = !out_valid_reg || m_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign div_inc   = div_cnt_reg + 8'd1;
    assign bit_inc   = bit_cnt_reg + 7'd1;
    assign start_rd  = cmd.data[5];
    assign start_data = start_rd ? 16'd0 :
                        ((cmd.data[5:4] == mdio45_pkg::OP_ADDRESS) ? reg_addr_reg : wdata_reg);

    always_comb begin
        port_addr_next = port_addr_reg;
        dev_addr_next  = dev_addr_reg;
        opcode_next    = opcode_reg;
        if_sel_next    = if_sel_reg;
        reg_addr_next  = reg_addr_reg;
        wdata_next     = wdata_reg;
        rdata_next     = rdata_reg;
        busy_next      = busy_reg;
        rvalid_next    = rvalid_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        clk_lvl_next   = clk_lvl_reg;
        ta_next        = ta_reg;
        read_byte_next = 8'd0;

        case (cmd.kind)
            mdio45_pkg::CMD_READ: begin
                case (cmd.sel)
                    mdio45_pkg::REG_CMD:
                        read_byte_next = {2'b00, opcode_reg, if_sel_reg, busy_reg, rvalid_reg};
                    mdio45_pkg::REG_DEV:    read_byte_next = {3'd0, dev_addr_reg};
                    mdio45_pkg::REG_PORT:   read_byte_next = {3'd0, port_addr_reg};
                    mdio45_pkg::REG_REG_HI: read_byte_next = reg_addr_reg[15:8];
                    mdio45_pkg::REG_REG_LO: read_byte_next = reg_addr_reg[7:0];
                    mdio45_pkg::REG_WD_HI:  read_byte_next = wdata_reg[15:8];
                    mdio45_pkg::REG_WD_LO:  read_byte_next = wdata_reg[7:0];
                    mdio45_pkg::REG_RD_HI:  read_byte_next = rdata_reg[15:8];
                    mdio45_pkg::REG_RD_LO:  read_byte_next = rdata_reg[7:0];
                    default:                read_byte_next = 8'd0;
                endcase
            end
            mdio45_pkg::CMD_WRITE: begin
                if (!busy_reg) begin
                    case (cmd.sel)
                        mdio45_pkg::REG_CMD: begin
                            opcode_next = cmd.data[5:4];
                            if_sel_next = cmd.data[3:2];
                            if (cmd.data[6]) begin
                                shift_next = mdio45_pkg::build_frame(cmd.data[5:4],
                                    port_addr_reg, dev_addr_reg,
                                    start_rd ? 2'b00 : 2'b10, start_data);
                                bit_cnt_next = 7'd0;
                                div_cnt_next = 8'd0;
                                clk_lvl_next = 1'b0;
                                ta_next      = 1'b1;
                                rvalid_next  = 1'b0;
                                busy_next    = 1'b1;
                            end
                        end
                        mdio45_pkg::REG_DEV:    dev_addr_next  = cmd.data[4:0];
                        mdio45_pkg::REG_PORT:   port_addr_next = cmd.data[4:0];
                        mdio45_pkg::REG_REG_HI: reg_addr_next  = {cmd.data, reg_addr_reg[7:0]};
                        mdio45_pkg::REG_REG_LO: reg_addr_next  = {reg_addr_reg[15:8], cmd.data};
                        mdio45_pkg::REG_WD_HI:  wdata_next     = {cmd.data, wdata_reg[7:0]};
                        mdio45_pkg::REG_WD_LO:  wdata_next     = {wdata_reg[15:8], cmd.data};
                        default: ;
                    endcase
                end
            end
            mdio45_pkg::CMD_TICK: begin
                if (busy_reg) begin
                    if (div_inc < mdio45_pkg::DIV_LIMIT) begin
                        div_cnt_next = div_inc;
                    end else begin
                        div_cnt_next = 8'd0;
                        if (!clk_lvl_reg) begin
                            clk_lvl_next = 1'b1;
                            if (opcode_reg[1]) begin
                                if (bit_cnt_reg == mdio45_pkg::BIT_TA_SAMPLE) begin
                                    ta_next = cmd.line;
                                end else if (bit_cnt_reg >= mdio45_pkg::BIT_DATA_FIRST) begin
                                    rdata_next = {rdata_reg[14:0], cmd.line};
                                end
                            end
                        end else begin
                            clk_lvl_next = 1'b0;
                            shift_next   = {shift_reg[62:0], 1'b0};
                            bit_cnt_next = bit_inc;
                            if (bit_inc >= mdio45_pkg::FRAME_LEN) begin
                                busy_next    = 1'b0;
                                bit_cnt_next = 7'd0;
                                if (opcode_reg[1] && !ta_reg) begin
                                    rvalid_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        drive_next    = busy_next &&
                        (!opcode_next[1] || (bit_cnt_next < mdio45_pkg::BIT_RELEASE));
        mdio_out_next = drive_next && shift_next[63];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_addr_reg <= 5'd0;
            dev_addr_reg  <= 5'd0;
            opcode_reg    <= 2'd0;
            if_sel_reg    <= 2'd0;
            reg_addr_reg  <= 16'd0;
            wdata_reg     <= 16'd0;
            rdata_reg     <= 16'd0;
            busy_reg      <= 1'b0;
            rvalid_reg    <= 1'b0;
            shift_reg     <= 64'd0;
            bit_cnt_reg   <= 7'd0;
            div_cnt_reg   <= 8'd0;
            clk_lvl_reg   <= 1'b0;
            ta_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                port_addr_reg <= port_addr_next;
                dev_addr_reg  <= dev_addr_next;
                opcode_reg    <= opcode_next;
                if_sel_reg    <= if_sel_next;
                reg_addr_reg  <= reg_addr_next;
                wdata_reg     <= wdata_next;
                rdata_reg     <= rdata_next;
                busy_reg      <= busy_next;
                rvalid_reg    <= rvalid_next;
                shift_reg     <= shift_next;
                bit_cnt_reg   <= bit_cnt_next;
                div_cnt_reg   <= div_cnt_next;
                clk_lvl_reg   <= clk_lvl_next;
                ta_reg        <= ta_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result beat payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            read_byte_reg <= read_byte_next;
            mdio_out_reg  <= mdio_out_next;
            drive_reg     <= drive_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_read_byte   = read_byte_reg;
    assign m_mdc         = clk_lvl_reg;
    assign m_mdio_out    = mdio_out_reg;
    assign m_mdio_drive  = drive_reg;
    assign m_port_select = if_sel_reg;
    assign m_busy_res    = busy_reg;

endmodule

@@ src/mdio_clause45_master_regs.sv @@
// ----------------------------------------------------------------------------
// mdio_clause45_master_regs
// Byte-wide register window with a Clause 45 MDIO master behind it.
// ----------------------------------------------------------------------------
// Each input beat is a register read or write, one clock tick or a no-op; each
// yields exactly one result beat reporting the read byte and the MDC/MDIO pin
// state after that beat. A new beat is taken every cycle while the queue has room:
// the classifier feeds a two-entry queue, and the execution stage retires one
// command per cycle into an output register, so each beat is registered in a
// queue entry and then in the output register; the sustained rate is one beat
// per cycle, limited only by the result side taking beats. Writing the start
// bit at offset 0x61 while idle launches a 64-bit frame; MDC toggles every
// MDC_HALF_PERIOD ticks and register writes are dropped while busy.
module mdio_clause45_master_regs (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_reg_offset,
    input  logic [7:0] s_write_byte,
    input  logic       s_mdio_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic       m_mdc,
    output logic       m_mdio_out,
    output logic       m_mdio_drive,
    output logic [1:0] m_port_select,
    output logic       m_busy_res
);

    mdio45_pkg::cmd_t in_cmd;
    mdio45_pkg::cmd_t q_cmd;
    logic             q_valid;
    logic             q_ready;

    mdio45_front u_front (
        .mode       (s_mode),
        .reg_offset (s_reg_offset),
        .write_byte (s_write_byte),
        .mdio_in    (s_mdio_in),
        .cmd        (in_cmd)
    );

    mdio45_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_cmd   (in_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    mdio45_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_byte   (m_read_byte),
        .m_mdc         (m_mdc),
        .m_mdio_out    (m_mdio_out),
        .m_mdio_drive  (m_mdio_drive),
        .m_port_select (m_port_select),
        .m_busy_res    (m_busy_res)
    );

endmodule

@@ tb/tb_mdio_clause45_master_regs.sv @@
// ----------------------------------------------------------------------------
// tb_mdio_clause45_master_regs
// Self-checking bench for the Clause 45 MDIO master register window: a short
// table of directed register beats, then register setup, frame launch and
// tick sequences with random content, all checked beat by beat against an
// in-bench model of the register file and the MDC/MDIO shifter.
// ----------------------------------------------------------------------------
module tb_mdio_clause45_master_regs;

    localparam int CYCLE_LIMIT = 400000;
    localparam int START_BIT   = 6;
    localparam logic [1:0] TA_DRIVEN = 2'b10;
    localparam logic [1:0] TA_FLOAT  = 2'b00;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       mdc;
        logic       mdio_out;
        logic       mdio_drive;
        logic [1:0] port_select;
        logic       busy;
    } pins_t;

    typedef struct packed {
        mdio45_pkg::cmd_kind_t kind;
        logic [7:0]            ofs;
        logic [7:0]            data;
        logic                  line;
        logic                  typed;
        logic [7:0]            rb;
    } beat_row_t;

    localparam int N_ROWS = 25;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = mdio45_pkg::CMD_NOP;
    logic [7:0] s_reg_offset = 8'h00;
    logic [7:0] s_write_byte = 8'h00;
    logic       s_mdio_in = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_byte;
    logic       m_mdc;
    logic       m_mdio_out;
    logic       m_mdio_drive;
    logic [1:0] m_port_select;
    logic       m_busy_res;

    pins_t expected_pins[$];
    int    errors = 0;
    int    cycles = 0;
    int    beats_sent = 0;
    bit    steady = 1'b0;

    // model state
    logic [4:0]  p_port, p_dev;
    logic [1:0]  p_op, p_isel;
    logic [15:0] p_regaddr, p_wdata, p_rdata;
    logic        p_busy, p_rvalid, p_mdc, p_ta;
    logic [63:0] p_shift;
    logic [6:0]  p_bits;
    logic [7:0]  p_div;

    beat_row_t plan [0:N_ROWS-1] = '{
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_CMD,    8'h00, 1'b0, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_DEV,    8'h00, 1'b0, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_RD_LO,  8'h00, 1'b0, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_TICK,  8'h00,                  8'h00, 1'b1, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_NOP,   8'hff,                  8'hff, 1'b1, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_DEV,    8'hff, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_DEV,    8'h00, 1'b0, 1'b1, 8'h1f},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_PORT,   8'hff, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_PORT,   8'h00, 1'b0, 1'b1, 8'h1f},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_REG_HI, 8'hff, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_REG_LO, 8'h00, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_REG_HI, 8'h00, 1'b0, 1'b1, 8'hff},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_WD_LO,  8'hff, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_WD_LO,  8'h00, 1'b0, 1'b1, 8'hff},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_RD_HI,  8'hab, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_RD_HI,  8'h00, 1'b0, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_WRITE, 8'hbf,                  8'hff, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  8'hbf,                  8'h00, 1'b0, 1'b1, 8'h00},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_CMD,    8'hbc, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_CMD,    8'h00, 1'b0, 1'b1, 8'h3c},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_CMD,    8'h7f, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_CMD,    8'h00, 1'b0, 1'b1, 8'h3e},
        '{mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_DEV,    8'h00, 1'b0, 1'b0, 8'h00},
        '{mdio45_pkg::CMD_READ,  mdio45_pkg::OFS_DEV,    8'h00, 1'b0, 1'b1, 8'h1f},
        '{mdio45_pkg::CMD_READ,  8'h00,                  8'h00, 1'b0, 1'b1, 8'h00}
    };

    mdio_clause45_master_regs dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_reg_offset  (s_reg_offset),
        .s_write_byte  (s_write_byte),
        .s_mdio_in     (s_mdio_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_byte   (m_read_byte),
        .m_mdc         (m_mdc),
        .m_mdio_out    (m_mdio_out),
        .m_mdio_drive  (m_mdio_drive),
        .m_port_select (m_port_select),
        .m_busy_res    (m_busy_res)
    );

    always #5 aclk = ~aclk;

    function automatic void master_reset();
        p_port = '0; p_dev = '0; p_op = '0; p_isel = '0;
        p_regaddr = '0; p_wdata = '0; p_rdata = '0;
        p_busy = 1'b0; p_rvalid = 1'b0; p_mdc = 1'b0; p_ta = 1'b1;
        p_shift = '0; p_bits = '0; p_div = '0;
    endfunction

    function automatic pins_t master_step(mdio45_pkg::cmd_kind_t kind, logic [7:0] ofs,
                                          logic [7:0] data, logic line);
        pins_t       r;
        logic [31:0] word;
        logic [15:0] payload;
        logic        drive;
        r = '0;
        case (kind)
            mdio45_pkg::CMD_READ: begin
                case (ofs)
                    mdio45_pkg::OFS_CMD:
                        r.read_byte = {2'b00, p_op, p_isel, p_busy, p_rvalid};
                    mdio45_pkg::OFS_DEV:    r.read_byte = {3'b000, p_dev};
                    mdio45_pkg::OFS_PORT:   r.read_byte = {3'b000, p_port};
                    mdio45_pkg::OFS_REG_HI: r.read_byte = p_regaddr[15:8];
                    mdio45_pkg::OFS_REG_LO: r.read_byte = p_regaddr[7:0];
                    mdio45_pkg::OFS_WD_HI:  r.read_byte = p_wdata[15:8];
                    mdio45_pkg::OFS_WD_LO:  r.read_byte = p_wdata[7:0];
                    mdio45_pkg::OFS_RD_HI:  r.read_byte = p_rdata[15:8];
                    mdio45_pkg::OFS_RD_LO:  r.read_byte = p_rdata[7:0];
                    default:                r.read_byte = 8'h00;
                endcase
            end
            mdio45_pkg::CMD_WRITE: begin
                if (!p_busy) begin
                    case (ofs)
                        mdio45_pkg::OFS_CMD: begin
                            p_op = data[5:4];
                            p_isel = data[3:2];
                            if (data[START_BIT]) begin
                                payload = p_op[1] ? 16'h0000 :
                                          (p_op == mdio45_pkg::OP_ADDRESS) ?
                                          p_regaddr : p_wdata;
                                word = {2'b00, p_op, p_port, p_dev,
                                        p_op[1] ? TA_FLOAT : TA_DRIVEN, payload};
                                p_shift = ~({64{1'b1}} >> mdio45_pkg::PREAMBLE_BITS) |
                                          ({32'd0, word} << (32 - mdio45_pkg::PREAMBLE_BITS));
                                p_bits = '0; p_div = '0; p_mdc = 1'b0; p_ta = 1'b1;
                                p_rvalid = 1'b0; p_busy = 1'b1;
                            end
                        end
                        mdio45_pkg::OFS_DEV:    p_dev = data[4:0];
                        mdio45_pkg::OFS_PORT:   p_port = data[4:0];
                        mdio45_pkg::OFS_REG_HI: p_regaddr[15:8] = data;
                        mdio45_pkg::OFS_REG_LO: p_regaddr[7:0] = data;
                        mdio45_pkg::OFS_WD_HI:  p_wdata[15:8] = data;
                        mdio45_pkg::OFS_WD_LO:  p_wdata[7:0] = data;
                        default: ;
                    endcase
                end
            end
            mdio45_pkg::CMD_TICK: begin
                if (p_busy) begin
                    p_div = p_div + 8'd1;
                    if (p_div >= mdio45_pkg::MDC_HALF_PERIOD) begin
                        p_div = '0;
                        if (!p_mdc) begin
                            p_mdc = 1'b1;
                            if (p_op[1]) begin
                                if (p_bits == mdio45_pkg::PREAMBLE_BITS + 15)
                                    p_ta = line;
                                else if (p_bits >= mdio45_pkg::PREAMBLE_BITS + 16)
                                    p_rdata = {p_rdata[14:0], line};
                            end
                        end else begin
                            p_mdc = 1'b0;
                            p_shift = p_shift << 1;
                            p_bits = p_bits + 7'd1;
                            if (p_bits >= mdio45_pkg::PREAMBLE_BITS + 32) begin
                                p_busy = 1'b0;
                                p_bits = '0;
                                if (p_op[1] && !p_ta)
                                    p_rvalid = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        drive = p_busy && (!p_op[1] || p_bits < mdio45_pkg::PREAMBLE_BITS + 14);
        r.mdc = p_mdc;
        r.mdio_out = drive ? p_shift[63] : 1'b0;
        r.mdio_drive = drive;
        r.port_select = p_isel;
        r.busy = p_busy;
        return r;
    endfunction

    task automatic report(string field, logic [7:0] got, logic [7:0] want);
        if (errors < 100)
            $display("mismatch on %s: got %02h, want %02h", field, got, want);
        errors++;
    endtask

    task automatic send(mdio45_pkg::cmd_kind_t kind, logic [7:0] ofs, logic [7:0] data,
                        logic line, logic typed = 1'b0, logic [7:0] rb = 8'h00);
        pins_t want;
        steady = (beats_sent >= 700) && (beats_sent < 1300);
        if (!steady && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= kind;
        s_reg_offset <= ofs;
        s_write_byte <= data;
        s_mdio_in <= line;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = master_step(kind, ofs, data, line);
        if (typed)
            want.read_byte = rb;
        expected_pins.push_back(want);
        beats_sent++;
    endtask

    function automatic logic [7:0] pick_offset();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(mdio45_pkg::OFS_CMD, mdio45_pkg::OFS_RD_LO));
        return 8'($urandom_range(0, 191));
    endfunction

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge aclk) begin
        pins_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pins.size() == 0) begin
                report("unexpected beat", m_read_byte, 8'h00);
            end else begin
                e = expected_pins.pop_front();
                if (m_read_byte !== e.read_byte) report("read_byte", m_read_byte, e.read_byte);
                if (m_mdc !== e.mdc) report("mdc", {7'd0, m_mdc}, {7'd0, e.mdc});
                if (m_mdio_out !== e.mdio_out)
                    report("mdio_out", {7'd0, m_mdio_out}, {7'd0, e.mdio_out});
                if (m_mdio_drive !== e.mdio_drive)
                    report("mdio_drive", {7'd0, m_mdio_drive}, {7'd0, e.mdio_drive});
                if (m_port_select !== e.port_select)
                    report("port_select", {6'd0, m_port_select}, {6'd0, e.port_select});
                if (m_busy_res !== e.busy)
                    report("busy_res", {7'd0, m_busy_res}, {7'd0, e.busy});
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] ofs;
        master_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++)
            send(plan[i].kind, plan[i].ofs, plan[i].data, plan[i].line,
                 plan[i].typed, plan[i].rb);

        while (beats_sent < 1800) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat (20)
                    send(mdio45_pkg::cmd_kind_t'($urandom_range(0, 3)), pick_offset(),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                // set up the frame fields, then launch
                repeat ($urandom_range(0, 7)) begin
                    ofs = pick_offset();
                    if ($urandom_range(0, 4) == 0)
                        send(mdio45_pkg::CMD_READ, ofs, 8'($urandom_range(0, 255)), 1'b0);
                    else
                        send(mdio45_pkg::CMD_WRITE, ofs, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                end
                send(mdio45_pkg::CMD_WRITE, mdio45_pkg::OFS_CMD,
                     8'($urandom_range(0, 255)) | (8'h01 << START_BIT), 1'b0);
                while (p_busy && beats_sent < 1800) begin
                    if ($urandom_range(0, 19) == 0)
                        send(mdio45_pkg::cmd_kind_t'($urandom_range(0, 3)), pick_offset(),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    else
                        send(mdio45_pkg::CMD_TICK, pick_offset(),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                send(mdio45_pkg::CMD_READ, mdio45_pkg::OFS_RD_HI, 8'h00, 1'b0);
                send(mdio45_pkg::CMD_READ, mdio45_pkg::OFS_RD_LO, 8'h00, 1'b0);
                send(mdio45_pkg::CMD_READ, mdio45_pkg::OFS_CMD, 8'h00, 1'b0);
            end
        end

        s_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
